// ----- hdl/fsct_pkg.sv -----
// Shared widths, codes and cell control types for the frequency-sorted count table.
package fsct_pkg;

   // Default sizing of the table
   localparam int NUM_TOPICS_DEF = 256;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed port widths
   localparam int CMD_W       = 2;
   localparam int TOPIC_W     = 8;
   localparam int RANK_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 16;
   localparam int LEN_W       = 9;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_OLD = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SAT    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd3;

   // Operation broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_MATCH,
      CELL_MARK_FIRST_LE,
      CELL_MARK_LAST_GE,
      CELL_MARK_INDEX,
      CELL_WRITE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic               sel_old;     // write source: old-topic hit instead of new-topic hit
      logic [TOPIC_W-1:0] key_new;
      logic [TOPIC_W-1:0] key_old;
      logic [TOPIC_W-1:0] wr_topic_a;  // lands in the hit cell
      logic [TOPIC_W-1:0] wr_topic_b;  // lands in the marked cell
   } cell_ctl_type;

   typedef struct packed {
      logic hit_new;
      logic hit_old;
      logic mark;
   } cell_flag_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_MATCH,
      S_MATCH_WAIT,
      S_EVAL,
      S_RAISE_MARK,
      S_RAISE_WAIT,
      S_RAISE_WRITE,
      S_APPEND_MARK,
      S_APPEND_WRITE,
      S_LOWER_MARK,
      S_LOWER_WAIT,
      S_LOWER_WRITE,
      S_READ_MARK,
      S_READ_WAIT,
      S_READ_DONE,
      S_FINISH
   } state_type;

endpackage

// ----- hdl/frequency_sorted_count_table_unit.sv -----
// Frequency-sorted count table: a row of NUM_TOPICS cells holds (topic, count) pairs in
// descending count order. Add raises a topic (or appends it with count 1) and swaps it ahead
// of the first entry with its old count; move takes one count from the source topic and gives
// it to the destination topic; read returns the entry at a rank. One transaction is worked on
// at a time. Every table step is a broadcast to all cells (compare or mark, using neighbor
// flags) followed by a registered gather of the flagged cell. If the previous result still
// waits on rsp_ready when the next one is done, the last step stretches until that result
// leaves. A new transaction is taken while the previous result still waits on rsp_ready.
// No clearing pass after reset: only live entries are ever looked at.
module frequency_sorted_count_table_unit #(
   parameter int NUM_TOPICS = fsct_pkg::NUM_TOPICS_DEF,
   parameter int COUNT_BITS = fsct_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fsct_pkg::CMD_W-1:0]       req_cmd,
   input  logic [fsct_pkg::TOPIC_W-1:0]     req_src_topic,
   input  logic [fsct_pkg::TOPIC_W-1:0]     req_dst_topic,
   input  logic [fsct_pkg::RANK_W-1:0]      req_read_rank,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fsct_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fsct_pkg::TOPIC_W-1:0]     rsp_topic_out,
   output logic [fsct_pkg::COUNT_OUT_W-1:0] rsp_count_out,
   output logic [fsct_pkg::RANK_W-1:0]      rsp_rank_out,
   output logic [fsct_pkg::LEN_W-1:0]       rsp_list_length
);

   localparam int IDX_W  = $clog2(NUM_TOPICS);
   localparam int LIVE_W = $clog2(NUM_TOPICS+1);
   localparam int CNT_W  = COUNT_BITS;
   localparam int TOP_W  = fsct_pkg::TOPIC_W;
   localparam int RNK_W  = fsct_pkg::RANK_W;
   localparam int COUT_W = fsct_pkg::COUNT_OUT_W;
   localparam int LEN_W  = fsct_pkg::LEN_W;
   localparam int STAT_W = fsct_pkg::STATUS_W;
   localparam int CMD_W  = fsct_pkg::CMD_W;
   localparam int RCMP_W = (LIVE_W > RNK_W) ? LIVE_W : RNK_W;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Sequencer and transaction registers
   fsct_pkg::state_type state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [TOP_W-1:0]    old_ff, old_in;
   logic [TOP_W-1:0]    new_ff, new_in;
   logic [RNK_W-1:0]    rank_ff, rank_in;
   logic                lowered_ff, lowered_in;
   logic [LIVE_W-1:0]   live_ff, live_in;

   // Finished result, staged until the output slot frees
   logic                res_load;
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [TOP_W-1:0]    res_topic_ff, res_topic_in;
   logic [COUT_W-1:0]   res_count_ff, res_count_in;
   logic [RNK_W-1:0]    res_rank_ff, res_rank_in;
   logic [LEN_W-1:0]    res_len_ff, res_len_in;

   // Output register
   logic                rsp_load;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [TOP_W-1:0]    rsp_topic_ff, rsp_topic_in;
   logic [COUT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [RNK_W-1:0]    rsp_rank_ff, rsp_rank_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   // Cell row broadcast and returns
   fsct_pkg::cell_ctl_type  cell_ctl;
   logic [CNT_W-1:0]        key_count;
   logic [IDX_W-1:0]        key_index;
   logic [CNT_W-1:0]        wr_count_a;
   logic [CNT_W-1:0]        wr_count_b;
   logic [NUM_TOPICS-1:0]   le_vec, ge_vec, left_le_vec, right_ge_vec;
   logic [NUM_TOPICS-1:0]   hit_new_vec, hit_old_vec, mark_vec;
   fsct_pkg::cell_flag_type flag_arr [NUM_TOPICS];
   logic [TOP_W-1:0]        topic_arr [NUM_TOPICS];
   logic [CNT_W-1:0]        count_arr [NUM_TOPICS];

   // Gathered values
   logic                    g_new_found;
   logic [IDX_W-1:0]        g_new_idx;
   logic [CNT_W-1:0]        g_new_count;
   logic                    g_old_found;
   logic [CNT_W-1:0]        g_old_count;
   logic [TOP_W-1:0]        g_mark_topic;
   logic [CNT_W-1:0]        g_mark_count;
   logic [IDX_W-1:0]        g_mark_idx;

   logic                    live_full;

   // Row of cells, each chained to its neighbors
   for (genvar i = 0; i < NUM_TOPICS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_le_vec[i] = 1'b0;
      end else begin : g_left
         assign left_le_vec[i] = le_vec[i-1];
      end
      if (i == NUM_TOPICS-1) begin : g_last
         assign right_ge_vec[i] = 1'b0;
      end else begin : g_right
         assign right_ge_vec[i] = ge_vec[i+1];
      end

      fsct_cell #(
         .INDEX      (i),
         .NUM_TOPICS (NUM_TOPICS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .key_count  (key_count),
         .key_index  (key_index),
         .live_count (live_ff),
         .wr_count_a (wr_count_a),
         .wr_count_b (wr_count_b),
         .left_le    (left_le_vec[i]),
         .right_ge   (right_ge_vec[i]),
         .le_o       (le_vec[i]),
         .ge_o       (ge_vec[i]),
         .flag_o     (flag_arr[i]),
         .topic_o    (topic_arr[i]),
         .count_o    (count_arr[i])
      );

      assign hit_new_vec[i] = flag_arr[i].hit_new;
      assign hit_old_vec[i] = flag_arr[i].hit_old;
      assign mark_vec[i]    = flag_arr[i].mark;
   end

   fsct_gather #(
      .NUM_TOPICS (NUM_TOPICS),
      .COUNT_BITS (COUNT_BITS)
   ) u_gather (
      .clock       (clock),
      .reset       (reset),
      .hit_new_vec (hit_new_vec),
      .hit_old_vec (hit_old_vec),
      .mark_vec    (mark_vec),
      .topic_arr   (topic_arr),
      .count_arr   (count_arr),
      .new_found   (g_new_found),
      .new_idx     (g_new_idx),
      .new_count   (g_new_count),
      .old_found   (g_old_found),
      .old_count   (g_old_count),
      .mark_topic  (g_mark_topic),
      .mark_count  (g_mark_count),
      .mark_idx    (g_mark_idx)
   );

   assign live_full = (live_ff == LIVE_W'(NUM_TOPICS));
   assign req_ready = (state_ff == fsct_pkg::S_IDLE);

   // Next state, cell broadcast and result staging
   always_comb begin
      state_in            = state_ff;
      cmd_in              = cmd_ff;
      old_in              = old_ff;
      new_in              = new_ff;
      rank_in             = rank_ff;
      lowered_in          = lowered_ff;
      live_in             = live_ff;
      cell_ctl            = '0;
      cell_ctl.op         = fsct_pkg::CELL_HOLD;
      cell_ctl.key_new    = new_ff;
      cell_ctl.key_old    = old_ff;
      cell_ctl.wr_topic_a = g_mark_topic;
      cell_ctl.wr_topic_b = new_ff;
      key_count           = '0;
      key_index           = '0;
      wr_count_a          = '0;
      wr_count_b          = '0;
      res_load            = 1'b0;
      res_status_in       = fsct_pkg::STAT_OK;
      res_topic_in        = '0;
      res_count_in        = '0;
      res_rank_in         = '0;
      res_len_in          = LEN_W'(live_ff);
      rsp_load            = 1'b0;

      case (state_ff)
         fsct_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               old_in     = req_src_topic;
               new_in     = req_dst_topic;
               rank_in    = req_read_rank;
               lowered_in = 1'b0;
               case (req_cmd)
                  fsct_pkg::CMD_ADD, fsct_pkg::CMD_MOVE: begin
                     state_in = fsct_pkg::S_MATCH;
                  end
                  fsct_pkg::CMD_READ: begin
                     state_in = fsct_pkg::S_READ_MARK;
                  end
                  default: begin
                     // unused command: empty ok result
                     res_load = 1'b1;
                     state_in = fsct_pkg::S_FINISH;
                  end
               endcase
            end
         end

         fsct_pkg::S_MATCH: begin
            cell_ctl.op = fsct_pkg::CELL_MATCH;
            state_in    = fsct_pkg::S_MATCH_WAIT;
         end

         fsct_pkg::S_MATCH_WAIT: begin
            state_in = fsct_pkg::S_EVAL;
         end

         fsct_pkg::S_EVAL: begin
            if (cmd_ff == fsct_pkg::CMD_MOVE && !lowered_ff) begin
               // first half of a move: checks, then lower the old topic
               if (old_ff == new_ff) begin
                  res_load = 1'b1;
                  state_in = fsct_pkg::S_FINISH;
                  if (g_new_found) begin
                     res_topic_in = new_ff;
                     res_count_in = COUT_W'(g_new_count);
                     res_rank_in  = RNK_W'(g_new_idx);
                  end else begin
                     res_status_in = fsct_pkg::STAT_NO_OLD;
                  end
               end else if (!g_old_found) begin
                  res_load      = 1'b1;
                  res_status_in = fsct_pkg::STAT_NO_OLD;
                  state_in      = fsct_pkg::S_FINISH;
               end else if (g_new_found && g_new_count == CNT_MAX) begin
                  res_load      = 1'b1;
                  res_status_in = fsct_pkg::STAT_SAT;
                  res_topic_in  = new_ff;
                  res_count_in  = COUT_W'(g_new_count);
                  res_rank_in   = RNK_W'(g_new_idx);
                  state_in      = fsct_pkg::S_FINISH;
               end else if (!g_new_found && g_old_count > CNT_W'(1) && live_full) begin
                  res_load      = 1'b1;
                  res_status_in = fsct_pkg::STAT_SAT;
                  state_in      = fsct_pkg::S_FINISH;
               end else begin
                  state_in = fsct_pkg::S_LOWER_MARK;
               end
            end else begin
               // add, or second half of a move
               if (g_new_found && g_new_count == CNT_MAX) begin
                  res_load      = 1'b1;
                  res_status_in = fsct_pkg::STAT_SAT;
                  res_topic_in  = new_ff;
                  res_count_in  = COUT_W'(g_new_count);
                  res_rank_in   = RNK_W'(g_new_idx);
                  state_in      = fsct_pkg::S_FINISH;
               end else if (!g_new_found && live_full) begin
                  res_load      = 1'b1;
                  res_status_in = fsct_pkg::STAT_SAT;
                  state_in      = fsct_pkg::S_FINISH;
               end else if (g_new_found) begin
                  state_in = fsct_pkg::S_RAISE_MARK;
               end else begin
                  state_in = fsct_pkg::S_APPEND_MARK;
               end
            end
         end

         // raise: swap with the first entry holding the same count
         fsct_pkg::S_RAISE_MARK: begin
            cell_ctl.op = fsct_pkg::CELL_MARK_FIRST_LE;
            key_count   = g_new_count;
            state_in    = fsct_pkg::S_RAISE_WAIT;
         end

         fsct_pkg::S_RAISE_WAIT: begin
            state_in = fsct_pkg::S_RAISE_WRITE;
         end

         fsct_pkg::S_RAISE_WRITE: begin
            cell_ctl.op         = fsct_pkg::CELL_WRITE;
            cell_ctl.wr_topic_a = g_mark_topic;
            cell_ctl.wr_topic_b = new_ff;
            wr_count_a          = g_new_count;
            wr_count_b          = g_new_count + CNT_W'(1);
            res_load            = 1'b1;
            res_topic_in        = new_ff;
            res_count_in        = COUT_W'(g_new_count + CNT_W'(1));
            res_rank_in         = RNK_W'(g_mark_idx);
            state_in            = fsct_pkg::S_FINISH;
         end

         // append at the end of the live list
         fsct_pkg::S_APPEND_MARK: begin
            cell_ctl.op = fsct_pkg::CELL_MARK_INDEX;
            key_index   = IDX_W'(live_ff);
            state_in    = fsct_pkg::S_APPEND_WRITE;
         end

         fsct_pkg::S_APPEND_WRITE: begin
            cell_ctl.op         = fsct_pkg::CELL_WRITE;
            cell_ctl.wr_topic_b = new_ff;
            wr_count_b          = CNT_W'(1);
            live_in             = live_ff + LIVE_W'(1);
            res_load            = 1'b1;
            res_topic_in        = new_ff;
            res_count_in        = COUT_W'(1);
            res_rank_in         = RNK_W'(live_ff);
            res_len_in          = LEN_W'(live_ff + LIVE_W'(1));
            state_in            = fsct_pkg::S_FINISH;
         end

         // lower: swap with the last entry of equal count, or with the last entry on removal
         fsct_pkg::S_LOWER_MARK: begin
            cell_ctl.op = fsct_pkg::CELL_MARK_LAST_GE;
            key_count   = (g_old_count <= CNT_W'(1)) ? '0 : g_old_count;
            state_in    = fsct_pkg::S_LOWER_WAIT;
         end

         fsct_pkg::S_LOWER_WAIT: begin
            state_in = fsct_pkg::S_LOWER_WRITE;
         end

         fsct_pkg::S_LOWER_WRITE: begin
            cell_ctl.op         = fsct_pkg::CELL_WRITE;
            cell_ctl.sel_old    = 1'b1;
            cell_ctl.wr_topic_a = g_mark_topic;
            cell_ctl.wr_topic_b = old_ff;
            wr_count_a          = g_mark_count;
            wr_count_b          = g_old_count - CNT_W'(1);
            if (g_old_count <= CNT_W'(1)) begin
               live_in = live_ff - LIVE_W'(1);
            end
            lowered_in = 1'b1;
            state_in   = fsct_pkg::S_MATCH;
         end

         fsct_pkg::S_READ_MARK: begin
            cell_ctl.op = fsct_pkg::CELL_MARK_INDEX;
            key_index   = IDX_W'(rank_ff);
            state_in    = fsct_pkg::S_READ_WAIT;
         end

         fsct_pkg::S_READ_WAIT: begin
            state_in = fsct_pkg::S_READ_DONE;
         end

         fsct_pkg::S_READ_DONE: begin
            res_load = 1'b1;
            state_in = fsct_pkg::S_FINISH;
            if (RCMP_W'(rank_ff) >= RCMP_W'(live_ff)) begin
               res_status_in = fsct_pkg::STAT_RANGE;
            end else begin
               res_topic_in = g_mark_topic;
               res_count_in = COUT_W'(g_mark_count);
               res_rank_in  = rank_ff;
            end
         end

         fsct_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = fsct_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fsct_pkg::S_IDLE;
         end
      endcase
   end

   // Output register next values
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_topic_in  = rsp_topic_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_len_in    = rsp_len_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_topic_in  = res_topic_ff;
         rsp_count_in  = res_count_ff;
         rsp_rank_in   = res_rank_ff;
         rsp_len_in    = res_len_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsct_pkg::S_IDLE;
         live_ff      <= '0;
         lowered_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         lowered_ff   <= lowered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      old_ff        <= old_in;
      new_ff        <= new_in;
      rank_ff       <= rank_in;
      rsp_status_ff <= rsp_status_in;
      rsp_topic_ff  <= rsp_topic_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_len_ff    <= rsp_len_in;
      if (res_load) begin
         res_status_ff <= res_status_in;
         res_topic_ff  <= res_topic_in;
         res_count_ff  <= res_count_in;
         res_rank_ff   <= res_rank_in;
         res_len_ff    <= res_len_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_topic_out   = rsp_topic_ff;
   assign rsp_count_out   = rsp_count_ff;
   assign rsp_rank_out    = rsp_rank_ff;
   assign rsp_list_length = rsp_len_ff;

`ifndef SYNTHESIS
   // Topics are unique in the list, so at most one cell can match
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_new_vec))
      else $error("more than one cell matched the new topic");

   // Every mark operation selects at most one slot
   a_mark_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(mark_vec))
      else $error("more than one cell marked");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIVE_W'(NUM_TOPICS))
      else $error("live entry count beyond table size");

   // List length moves only on an append or a removal write
   a_live_change: assert property (@(posedge clock) disable iff (reset)
      (live_ff != $past(live_ff)) |->
         ($past(state_ff) == fsct_pkg::S_APPEND_WRITE ||
          $past(state_ff) == fsct_pkg::S_LOWER_WRITE))
      else $error("live entry count changed outside a table write");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == fsct_pkg::S_FINISH))
      else $error("result presented without a finished transaction");
`endif

endmodule

// ----- hdl/fsct_cell.sv -----
// One table slot: holds a topic and its count, compares against the broadcast keys.
module fsct_cell #(
   parameter int INDEX      = 0,
   parameter int NUM_TOPICS = fsct_pkg::NUM_TOPICS_DEF,
   parameter int COUNT_BITS = fsct_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fsct_pkg::cell_ctl_type          ctl,
   input  logic [COUNT_BITS-1:0]           key_count,
   input  logic [$clog2(NUM_TOPICS)-1:0]   key_index,
   input  logic [$clog2(NUM_TOPICS+1)-1:0] live_count,
   input  logic [COUNT_BITS-1:0]           wr_count_a,
   input  logic [COUNT_BITS-1:0]           wr_count_b,
   input  logic                            left_le,
   input  logic                            right_ge,
   output logic                            le_o,
   output logic                            ge_o,
   output fsct_pkg::cell_flag_type         flag_o,
   output logic [fsct_pkg::TOPIC_W-1:0]    topic_o,
   output logic [COUNT_BITS-1:0]           count_o
);

   localparam int IDX_W  = $clog2(NUM_TOPICS);
   localparam int LIVE_W = $clog2(NUM_TOPICS+1);

   logic                         live_hit;
   logic                         take_a;
   logic [fsct_pkg::TOPIC_W-1:0] topic_ff, topic_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   fsct_pkg::cell_flag_type      flag_ff, flag_in;

   // Slot lies inside the live part of the list
   assign live_hit = (LIVE_W'(INDEX) < live_count);

   // Neighbor chain terms: counts are descending, so le is a suffix and ge a prefix
   assign le_o   = live_hit && (count_ff <= key_count);
   assign ge_o   = live_hit && (count_ff >= key_count);
   assign take_a = ctl.sel_old ? flag_ff.hit_old : flag_ff.hit_new;

   // Flag updates
   always_comb begin
      flag_in = flag_ff;
      case (ctl.op)
         fsct_pkg::CELL_MATCH: begin
            flag_in.hit_new = live_hit && (topic_ff == ctl.key_new);
            flag_in.hit_old = live_hit && (topic_ff == ctl.key_old);
         end
         fsct_pkg::CELL_MARK_FIRST_LE: begin
            flag_in.mark = le_o && !left_le;
         end
         fsct_pkg::CELL_MARK_LAST_GE: begin
            flag_in.mark = ge_o && !right_ge;
         end
         fsct_pkg::CELL_MARK_INDEX: begin
            flag_in.mark = (IDX_W'(INDEX) == key_index);
         end
         default: begin
         end
      endcase
   end

   // Swap / store: marked cell takes side b, hit cell takes side a
   always_comb begin
      topic_in = topic_ff;
      count_in = count_ff;
      if (ctl.op == fsct_pkg::CELL_WRITE) begin
         if (flag_ff.mark) begin
            topic_in = ctl.wr_topic_b;
            count_in = wr_count_b;
         end else if (take_a) begin
            topic_in = ctl.wr_topic_a;
            count_in = wr_count_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      topic_ff <= topic_in;
      count_ff <= count_in;
   end

   assign flag_o  = flag_ff;
   assign topic_o = topic_ff;
   assign count_o = count_ff;

endmodule

// ----- hdl/fsct_gather.sv -----
// Registered OR-gather of the flagged cells' index, topic and count.
module fsct_gather #(
   parameter int NUM_TOPICS = fsct_pkg::NUM_TOPICS_DEF,
   parameter int COUNT_BITS = fsct_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [NUM_TOPICS-1:0]         hit_new_vec,
   input  logic [NUM_TOPICS-1:0]         hit_old_vec,
   input  logic [NUM_TOPICS-1:0]         mark_vec,
   input  logic [fsct_pkg::TOPIC_W-1:0]  topic_arr [NUM_TOPICS],
   input  logic [COUNT_BITS-1:0]         count_arr [NUM_TOPICS],
   output logic                          new_found,
   output logic [$clog2(NUM_TOPICS)-1:0] new_idx,
   output logic [COUNT_BITS-1:0]         new_count,
   output logic                          old_found,
   output logic [COUNT_BITS-1:0]         old_count,
   output logic [fsct_pkg::TOPIC_W-1:0]  mark_topic,
   output logic [COUNT_BITS-1:0]         mark_count,
   output logic [$clog2(NUM_TOPICS)-1:0] mark_idx
);

   localparam int IDX_W = $clog2(NUM_TOPICS);
   localparam int TOP_W = fsct_pkg::TOPIC_W;

   logic                  new_found_ff, new_found_in;
   logic                  old_found_ff, old_found_in;
   logic [IDX_W-1:0]      new_idx_ff, new_idx_in;
   logic [COUNT_BITS-1:0] new_count_ff, new_count_in;
   logic [COUNT_BITS-1:0] old_count_ff, old_count_in;
   logic [TOP_W-1:0]      mark_topic_ff, mark_topic_in;
   logic [COUNT_BITS-1:0] mark_count_ff, mark_count_in;
   logic [IDX_W-1:0]      mark_idx_ff, mark_idx_in;

   // Flags are one-hot at most, so a plain OR picks the flagged cell
   always_comb begin
      new_found_in  = 1'b0;
      old_found_in  = 1'b0;
      new_idx_in    = '0;
      new_count_in  = '0;
      old_count_in  = '0;
      mark_topic_in = '0;
      mark_count_in = '0;
      mark_idx_in   = '0;
      for (int i = 0; i < NUM_TOPICS; i++) begin
         new_found_in  = new_found_in | hit_new_vec[i];
         old_found_in  = old_found_in | hit_old_vec[i];
         new_idx_in    = new_idx_in | ({IDX_W{hit_new_vec[i]}} & IDX_W'(i));
         new_count_in  = new_count_in | ({COUNT_BITS{hit_new_vec[i]}} & count_arr[i]);
         old_count_in  = old_count_in | ({COUNT_BITS{hit_old_vec[i]}} & count_arr[i]);
         mark_topic_in = mark_topic_in | ({TOP_W{mark_vec[i]}} & topic_arr[i]);
         mark_count_in = mark_count_in | ({COUNT_BITS{mark_vec[i]}} & count_arr[i]);
         mark_idx_in   = mark_idx_in | ({IDX_W{mark_vec[i]}} & IDX_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_found_ff <= 1'b0;
         old_found_ff <= 1'b0;
      end else begin
         new_found_ff <= new_found_in;
         old_found_ff <= old_found_in;
      end
   end

   always_ff @(posedge clock) begin
      new_idx_ff    <= new_idx_in;
      new_count_ff  <= new_count_in;
      old_count_ff  <= old_count_in;
      mark_topic_ff <= mark_topic_in;
      mark_count_ff <= mark_count_in;
      mark_idx_ff   <= mark_idx_in;
   end

   assign new_found  = new_found_ff;
   assign new_idx    = new_idx_ff;
   assign new_count  = new_count_ff;
   assign old_found  = old_found_ff;
   assign old_count  = old_count_ff;
   assign mark_topic = mark_topic_ff;
   assign mark_count = mark_count_ff;
   assign mark_idx   = mark_idx_ff;

endmodule
